// ===== hw/rtl/rgb2hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_pkg: shared types and helpers for the RGB to HSV converter
// Channel widths, pipeline depth, hue sector codes, stage records and the
// restoring-division step used by the divider pipeline.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

   localparam int ChanWidth   = 8;
   localparam int HueWidth    = 9;
   // one quotient bit per stage; both quotients are below 2**ChanWidth
   localparam int NumDivSteps = ChanWidth;
   // prep stage, numerator stage, divide steps, output register
   localparam int NumStages   = NumDivSteps + 3;
   localparam int LastStage   = NumStages - 1;

   localparam logic [HueWidth-1:0] HueOffsetRed   = 9'd0;
   localparam logic [HueWidth-1:0] HueOffsetGreen = 9'd120;
   localparam logic [HueWidth-1:0] HueOffsetBlue  = 9'd240;
   localparam logic [HueWidth-1:0] HueTurn        = 9'd360;

   typedef enum logic [1:0] {
      SectorRed,
      SectorGreen,
      SectorBlue
   } sector_type;

   // after max/min and sector selection
   typedef struct packed {
      logic [ChanWidth-1:0] maxv;
      logic [ChanWidth-1:0] minv;
      sector_type           sector;
      logic                 neg;
      logic [ChanWidth-1:0] mag;
   } prep_type;

   // one record per division stage; numerators shift out msb first
   typedef struct packed {
      logic [ChanWidth-1:0] maxv;
      logic [ChanWidth-1:0] delta;
      logic                 grey;
      sector_type           sector;
      logic                 neg;
      logic [ChanWidth-1:0] sat_rem;
      logic [ChanWidth-1:0] sat_num;
      logic [ChanWidth-1:0] sat_quo;
      logic [ChanWidth-1:0] hue_rem;
      logic [ChanWidth-1:0] hue_num;
      logic [ChanWidth-1:0] hue_quo;
   } div_type;

   // restoring step: returns {quotient bit, new remainder}
   function automatic logic [ChanWidth:0] div_step(
      input logic [ChanWidth-1:0] rem,
      input logic                 num_bit,
      input logic [ChanWidth-1:0] divisor
   );
      logic [ChanWidth:0] trial;
      logic [ChanWidth:0] diff;
      trial = {rem, num_bit};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         div_step = {1'b1, diff[ChanWidth-1:0]};
      end else begin
         div_step = {1'b0, trial[ChanWidth-1:0]};
      end
   endfunction

endpackage

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: pipelined 8-bit RGB to HSV conversion
// Value is the largest channel, saturation is 255*delta/max truncated, hue is
// the sector offset plus 60*diff/delta truncated toward zero, wrapped to 0..359.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_red, req_green, req_blue
//   rsp_      out        rsp_valid / rsp_stall  rsp_hue_degrees, rsp_saturation,
//                                               rsp_brightness
//
// Throughput: one pixel per clock while rsp_stall is low. The pipeline has 11
// register stages, from the prep stage through to the output register.
// The depth is set by the two 8-step restoring dividers (one quotient bit per
// stage), which run side by side, plus prep, numerator and output stages.
// Reset clears every stage's valid bit; payload registers are not reset.
// Stalls: each stage holds while it is full and the one after it cannot move,
// so empty stages close up behind a stalled response and nothing is lost.
//
module rgb_to_hsv_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rgb2hsv_pkg::ChanWidth-1:0]   req_red,
   input  logic [rgb2hsv_pkg::ChanWidth-1:0]   req_green,
   input  logic [rgb2hsv_pkg::ChanWidth-1:0]   req_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rgb2hsv_pkg::HueWidth-1:0]    rsp_hue_degrees,
   output logic [rgb2hsv_pkg::ChanWidth-1:0]   rsp_saturation,
   output logic [rgb2hsv_pkg::ChanWidth-1:0]   rsp_brightness
);
   import rgb2hsv_pkg::*;

   // ------------------------------------------------------------------
   // Flow control: a stage may load when it is empty or its content moves on.
   // ------------------------------------------------------------------
   logic [LastStage:0] valid_ff;
   logic [LastStage:0] adv;

   always_comb begin
      adv[LastStage] = !valid_ff[LastStage] || !rsp_stall;
      for (int k = LastStage - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[LastStage];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k <= LastStage; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: max, min, sector (red wins ties, then green) and the signed
   // channel difference used for hue, kept as sign and magnitude.
   // ------------------------------------------------------------------
   prep_type             prep_in;
   prep_type             prep_ff;
   logic                 red_top;
   logic                 green_top;
   logic [ChanWidth-1:0] first_chan;
   logic [ChanWidth-1:0] second_chan;

   always_comb begin
      red_top   = (req_red >= req_green) && (req_red >= req_blue);
      green_top = (req_green >= req_blue);

      priority if (red_top) begin
         prep_in.sector = SectorRed;
         prep_in.maxv   = req_red;
         first_chan     = req_green;
         second_chan    = req_blue;
      end else if (green_top) begin
         prep_in.sector = SectorGreen;
         prep_in.maxv   = req_green;
         first_chan     = req_blue;
         second_chan    = req_red;
      end else begin
         prep_in.sector = SectorBlue;
         prep_in.maxv   = req_blue;
         first_chan     = req_red;
         second_chan    = req_green;
      end

      priority if ((req_red <= req_green) && (req_red <= req_blue)) begin
         prep_in.minv = req_red;
      end else if (req_green <= req_blue) begin
         prep_in.minv = req_green;
      end else begin
         prep_in.minv = req_blue;
      end

      prep_in.neg = (first_chan < second_chan);
      prep_in.mag = prep_in.neg ? (second_chan - first_chan) : (first_chan - second_chan);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prep_ff <= prep_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: numerators 255*delta and 60*mag (16 bits). Both quotients are
   // below 256, so the upper byte already sits below the divisor and serves
   // as the starting remainder.
   // Stages 2..9: one restoring step per stage for each divider.
   // ------------------------------------------------------------------
   div_type                div_in [NumDivSteps+1];
   div_type                div_ff [NumDivSteps+1];
   logic [ChanWidth-1:0]   delta;
   logic [2*ChanWidth-1:0] sat_wide;
   logic [2*ChanWidth-1:0] hue_wide;
   logic [ChanWidth:0]     sat_step [NumDivSteps+1];
   logic [ChanWidth:0]     hue_step [NumDivSteps+1];

   always_comb begin
      delta    = prep_ff.maxv - prep_ff.minv;
      // x*255 = x*256 - x, x*60 = x*64 - x*4
      sat_wide = {delta, 8'd0} - {8'd0, delta};
      hue_wide = {2'd0, prep_ff.mag, 6'd0} - {6'd0, prep_ff.mag, 2'd0};

      div_in[0].maxv    = prep_ff.maxv;
      div_in[0].delta   = delta;
      div_in[0].grey    = (delta == '0);
      div_in[0].sector  = prep_ff.sector;
      div_in[0].neg     = prep_ff.neg;
      div_in[0].sat_rem = sat_wide[2*ChanWidth-1:ChanWidth];
      div_in[0].sat_num = sat_wide[ChanWidth-1:0];
      div_in[0].sat_quo = '0;
      div_in[0].hue_rem = hue_wide[2*ChanWidth-1:ChanWidth];
      div_in[0].hue_num = hue_wide[ChanWidth-1:0];
      div_in[0].hue_quo = '0;
      sat_step[0]       = '0;
      hue_step[0]       = '0;

      for (int j = 1; j <= NumDivSteps; j++) begin
         sat_step[j] = div_step(div_ff[j-1].sat_rem, div_ff[j-1].sat_num[ChanWidth-1],
                                div_ff[j-1].maxv);
         hue_step[j] = div_step(div_ff[j-1].hue_rem, div_ff[j-1].hue_num[ChanWidth-1],
                                div_ff[j-1].delta);
         div_in[j]         = div_ff[j-1];
         div_in[j].sat_rem = sat_step[j][ChanWidth-1:0];
         div_in[j].sat_num = {div_ff[j-1].sat_num[ChanWidth-2:0], 1'b0};
         div_in[j].sat_quo = {div_ff[j-1].sat_quo[ChanWidth-2:0], sat_step[j][ChanWidth]};
         div_in[j].hue_rem = hue_step[j][ChanWidth-1:0];
         div_in[j].hue_num = {div_ff[j-1].hue_num[ChanWidth-2:0], 1'b0};
         div_in[j].hue_quo = {div_ff[j-1].hue_quo[ChanWidth-2:0], hue_step[j][ChanWidth]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= NumDivSteps; j++) begin
         if (adv[j+1]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 10: sector offset plus signed quotient, wrap negatives by 360,
   // and force grey pixels (divide by zero) to hue and saturation zero.
   // ------------------------------------------------------------------
   div_type               fin;
   logic [HueWidth-1:0]   hue_base;
   logic [HueWidth:0]     hue_sum;
   logic [HueWidth-1:0]   hue_in;
   logic [ChanWidth-1:0]  sat_in;
   logic [HueWidth-1:0]   hue_ff;
   logic [ChanWidth-1:0]  sat_ff;
   logic [ChanWidth-1:0]  bright_ff;

   always_comb begin
      fin = div_ff[NumDivSteps];
      unique case (fin.sector)
         SectorRed:   hue_base = HueOffsetRed;
         SectorGreen: hue_base = HueOffsetGreen;
         SectorBlue:  hue_base = HueOffsetBlue;
         default:     hue_base = HueOffsetRed;
      endcase

      if (fin.neg) begin
         if ({1'b0, fin.hue_quo} > hue_base) begin
            // only the red sector goes below zero
            hue_sum = {1'b0, hue_base} + {1'b0, HueTurn} - {2'd0, fin.hue_quo};
         end else begin
            hue_sum = {1'b0, hue_base} - {2'd0, fin.hue_quo};
         end
      end else begin
         hue_sum = {1'b0, hue_base} + {2'd0, fin.hue_quo};
      end

      hue_in = fin.grey ? '0 : hue_sum[HueWidth-1:0];
      sat_in = fin.grey ? '0 : fin.sat_quo;
   end

   always_ff @(posedge clock) begin
      if (adv[LastStage]) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= fin.maxv;
      end
   end

   assign rsp_hue_degrees = hue_ff;
   assign rsp_saturation  = sat_ff;
   assign rsp_brightness  = bright_ff;

`ifndef SYNTHESIS
   // hue always wraps into one turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue_degrees < HueTurn))
      else $error("hue out of range");

   // a colored pixel always has nonzero saturation; grey gives zero hue
   a_grey_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_saturation == '0)) |-> (rsp_hue_degrees == '0))
      else $error("zero saturation with nonzero hue");

   // an accepted request always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request lost at entry");
`endif

endmodule
